// ===== hdl/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg: shared constants for the vector normalizer
// Holds the fixed format of the unit components.
// ----------------------------------------------------------------------------
package vn_pkg;

   // Unit components are signed Q1.15.
   localparam int UNIT_BITS = 16;
   localparam int UNIT_FRAC = 15;

   localparam logic [UNIT_BITS-1:0] UNIT_ONE     = 16'h8000;
   localparam logic [UNIT_BITS-1:0] UNIT_MAX_POS = 16'h7FFF;

   typedef logic signed [UNIT_BITS-1:0] unit_type;

endpackage

// ===== hdl/vn_if.sv =====
// ----------------------------------------------------------------------------
// vn_req_if / vn_rsp_if: valid-ready channels of the vector normalizer
// One carries the vector request, the other the normalized result.
// ----------------------------------------------------------------------------
interface vn_req_if #(parameter int COMPONENT_BITS = 16);
   logic                             valid;
   logic                             ready;
   logic signed [COMPONENT_BITS-1:0] x_value;
   logic signed [COMPONENT_BITS-1:0] y_value;
   logic signed [COMPONENT_BITS-1:0] z_value;

   modport source (output valid, x_value, y_value, z_value, input ready);
   modport sink   (input valid, x_value, y_value, z_value, output ready);
endinterface

interface vn_rsp_if #(parameter int COMPONENT_BITS = 16);
   logic                      valid;
   logic                      ready;
   logic [COMPONENT_BITS-1:0] length;
   logic signed [15:0]        unit_x;
   logic signed [15:0]        unit_y;
   logic signed [15:0]        unit_z;
   logic                      zero_vector;

   modport source (output valid, length, unit_x, unit_y, unit_z, zero_vector,
                   input ready);
   modport sink   (input valid, length, unit_x, unit_y, unit_z, zero_vector,
                   output ready);
endinterface

// ===== hdl/vn_sqrt.sv =====
// ----------------------------------------------------------------------------
// vn_sqrt: pipelined integer square root
// One root bit per stage, floor result, with a sideband tag carried along.
// ----------------------------------------------------------------------------
module vn_sqrt #(
   parameter int ROOT_BITS = 16,
   parameter int TAG_BITS  = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [2*ROOT_BITS-1:0] radicand,
   input  logic [TAG_BITS-1:0]    in_tag,
   output logic                   out_valid,
   output logic [ROOT_BITS-1:0]   root,
   output logic [TAG_BITS-1:0]    out_tag
);

   localparam int RW = ROOT_BITS + 2;

   logic [ROOT_BITS:0]        valid_ff;
   logic [RW-1:0]             rem_ff   [ROOT_BITS+1];
   logic [ROOT_BITS-1:0]      root_ff  [ROOT_BITS+1];
   logic [2*ROOT_BITS-1:0]    rad_ff   [ROOT_BITS+1];
   logic [TAG_BITS-1:0]       tag_ff   [ROOT_BITS+1];

   always_comb begin
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      rad_ff[0]  = radicand;
      tag_ff[0]  = in_tag;
      valid_ff[0] = in_valid;
   end

   for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
      logic [RW:0]          shifted;
      logic [RW:0]          trial;
      logic                 take;
      logic [RW-1:0]        rem_in;
      logic [ROOT_BITS-1:0] root_in;

      always_comb begin
         shifted = {rem_ff[s][RW-2:0], rad_ff[s][2*ROOT_BITS-1 -: 2]};
         trial   = {1'b0, root_ff[s], 2'b01};
         take    = (shifted >= trial);
         rem_in  = take ? RW'(shifted - trial) : RW'(shifted);
         root_in = {root_ff[s][ROOT_BITS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (advance) begin
            rem_ff[s+1]  <= rem_in;
            root_ff[s+1] <= root_in;
            rad_ff[s+1]  <= {rad_ff[s][2*ROOT_BITS-3:0], 2'b00};
            tag_ff[s+1]  <= tag_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_BITS];
   assign root      = root_ff[ROOT_BITS];
   assign out_tag   = tag_ff[ROOT_BITS];

endmodule

// ===== hdl/vn_div.sv =====
// ----------------------------------------------------------------------------
// vn_div: one divider lane
// Computes (mag << 15) / divisor, 16 quotient bits, one bit per stage.
// ----------------------------------------------------------------------------
module vn_div
   import vn_pkg::*;
#(
   parameter int COMPONENT_BITS = 16,
   parameter int TAG_BITS       = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [COMPONENT_BITS-1:0] magnitude,
   input  logic [COMPONENT_BITS-1:0] divisor,
   input  logic [TAG_BITS-1:0]       in_tag,
   output logic                      out_valid,
   output logic [UNIT_BITS-1:0]      quotient,
   output logic [COMPONENT_BITS-1:0] out_divisor,
   output logic [TAG_BITS-1:0]       out_tag
);

   localparam int W = COMPONENT_BITS;

   logic [UNIT_BITS:0]   valid_ff;
   logic [W-1:0]         rem_ff  [UNIT_BITS+1];
   logic [W-1:0]         den_ff  [UNIT_BITS+1];
   logic [UNIT_BITS-1:0] quo_ff  [UNIT_BITS+1];
   logic [TAG_BITS-1:0]  tag_ff  [UNIT_BITS+1];

   // The quotient never exceeds 2^15, so the upper dividend bits start as
   // the partial remainder; only the low magnitude bit is still to come.
   always_comb begin
      valid_ff[0] = in_valid;
      rem_ff[0]   = {1'b0, magnitude[W-1:1]};
      den_ff[0]   = divisor;
      quo_ff[0]   = '0;
      tag_ff[0]   = in_tag;
   end

   for (genvar s = 0; s < UNIT_BITS; s++) begin : g_stage
      logic [W:0]   shifted;
      logic         take;
      logic         next_bit;

      always_comb begin
         next_bit = (s == 0) ? magnitude[0] : 1'b0;
         shifted  = {rem_ff[s], next_bit};
         take     = (shifted >= {1'b0, den_ff[s]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (advance) begin
            rem_ff[s+1] <= take ? W'(shifted - {1'b0, den_ff[s]}) : W'(shifted);
            den_ff[s+1] <= den_ff[s];
            quo_ff[s+1] <= {quo_ff[s][UNIT_BITS-2:0], take};
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid   = valid_ff[UNIT_BITS];
   assign quotient    = quo_ff[UNIT_BITS];
   assign out_divisor = den_ff[UNIT_BITS];
   assign out_tag     = tag_ff[UNIT_BITS];

endmodule

// ===== hdl/vector3_normalize.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize: magnitude and unit direction of a three-axis vector
// Pipelined square root followed by three parallel divider lanes.
// ----------------------------------------------------------------------------
// The block accepts one vector request per clock cycle and returns one result
// per request, in order. A request passes through registered stages for the
// magnitudes, the squares and their sum, a stage per root bit in the square
// root pipeline, a stage per quotient bit in the divider lanes and the output
// register. The whole pipeline advances together whenever the output register
// is empty or being taken, so a stalled result holds every stage in place and
// the request side sees ready low. The length is the floor of the Euclidean
// magnitude; the unit components are signed Q1.15, truncated toward zero,
// with +1.0 saturating to 32767. A zero vector gives zero unit components and
// raises zero_vector.
// ----------------------------------------------------------------------------
module vector3_normalize
   import vn_pkg::*;
#(
   parameter int COMPONENT_BITS = 16
) (
   input  logic  clock,
   input  logic  reset,
   vn_req_if.sink   req,
   vn_rsp_if.source rsp
);

   localparam int W = COMPONENT_BITS;
   localparam int SQRT_TAG = 3 + 3 * W;

   // Global pipeline enable: every stage moves when the output can move.
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   // Stage 1: sign and magnitude of each component.
   logic         s1_valid_ff;
   logic [2:0]   s1_sign_ff;
   logic [W-1:0] s1_mag_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
      end
      if (advance) begin
         s1_sign_ff   <= {req.z_value[W-1], req.y_value[W-1], req.x_value[W-1]};
         s1_mag_ff[0] <= req.x_value[W-1] ? W'(-req.x_value) : W'(req.x_value);
         s1_mag_ff[1] <= req.y_value[W-1] ? W'(-req.y_value) : W'(req.y_value);
         s1_mag_ff[2] <= req.z_value[W-1] ? W'(-req.z_value) : W'(req.z_value);
      end
   end

   // Stage 2: squares, one multiplier per axis.
   logic           s2_valid_ff;
   logic [2:0]     s2_sign_ff;
   logic [W-1:0]   s2_mag_ff [3];
   logic [2*W-1:0] s2_sq_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_sign_ff <= s1_sign_ff;
         for (int i = 0; i < 3; i++) begin
            s2_mag_ff[i] <= s1_mag_ff[i];
            s2_sq_ff[i]  <= s1_mag_ff[i] * s1_mag_ff[i];
         end
      end
   end

   // Stage 3: sum of squares. It is at most 3 * 2^(2W-2), so 2W bits hold it.
   logic           s3_valid_ff;
   logic [2:0]     s3_sign_ff;
   logic [W-1:0]   s3_mag_ff [3];
   logic [2*W-1:0] s3_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_sign_ff <= s2_sign_ff;
         s3_mag_ff  <= s2_mag_ff;
         s3_sum_ff  <= (2*W)'(s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2]);
      end
   end

   // Square root; signs and magnitudes ride along as the tag.
   logic                sq_valid;
   logic [W-1:0]        sq_root;
   logic [SQRT_TAG-1:0] sq_tag;

   vn_sqrt #(
      .ROOT_BITS (W),
      .TAG_BITS  (SQRT_TAG)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_valid_ff),
      .radicand  (s3_sum_ff),
      .in_tag    ({s3_sign_ff, s3_mag_ff[2], s3_mag_ff[1], s3_mag_ff[0]}),
      .out_valid (sq_valid),
      .root      (sq_root),
      .out_tag   (sq_tag)
   );

   // Three divider lanes, one per axis; each carries its own sign.
   logic                 lane_valid [3];
   logic [UNIT_BITS-1:0] lane_quo   [3];
   logic [W-1:0]         lane_len   [3];
   logic                 lane_sign  [3];

   for (genvar l = 0; l < 3; l++) begin : g_lane
      vn_div #(
         .COMPONENT_BITS (W),
         .TAG_BITS       (1)
      ) u_div (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .in_valid    (sq_valid),
         .magnitude   (sq_tag[l*W +: W]),
         .divisor     (sq_root),
         .in_tag      (sq_tag[3*W + l]),
         .out_valid   (lane_valid[l]),
         .quotient    (lane_quo[l]),
         .out_divisor (lane_len[l]),
         .out_tag     (lane_sign[l])
      );
   end

   // Merge: apply signs, saturate +1.0, and clear everything for a zero vector.
   // The root is zero exactly when the sum of squares is zero.
   logic     zero_in;
   unit_type unit_in [3];

   always_comb begin
      zero_in = (lane_len[0] == '0);
      for (int i = 0; i < 3; i++) begin
         if (zero_in) begin
            unit_in[i] = '0;
         end else if (lane_sign[i]) begin
            unit_in[i] = (lane_quo[i] > UNIT_ONE) ? unit_type'(UNIT_ONE)
                                                  : unit_type'(-lane_quo[i]);
         end else begin
            unit_in[i] = (lane_quo[i] >= UNIT_ONE) ? unit_type'(UNIT_MAX_POS)
                                                   : unit_type'(lane_quo[i]);
         end
      end
   end

   // Output register.
   logic [W-1:0] length_ff;
   unit_type     unit_ff [3];
   logic         zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= lane_valid[0] && lane_valid[1] && lane_valid[2];
      end
      if (advance) begin
         length_ff <= lane_len[0];
         unit_ff   <= unit_in;
         zero_ff   <= zero_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.length      = length_ff;
   assign rsp.unit_x      = unit_ff[0];
   assign rsp.unit_y      = unit_ff[1];
   assign rsp.unit_z      = unit_ff[2];
   assign rsp.zero_vector = zero_ff;

   // A zero vector must come out with a zero length and zero unit components.
   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.zero_vector |->
         rsp.length == '0 && rsp.unit_x == '0 && rsp.unit_y == '0 && rsp.unit_z == '0)
      else $error("zero vector result carries nonzero fields");

   // A nonzero vector always has a nonzero length.
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.zero_vector |-> rsp.length != '0)
      else $error("nonzero vector with zero length");

   // The lanes run in lock step with one shared enable.
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      lane_valid[0] == lane_valid[1] && lane_valid[1] == lane_valid[2])
      else $error("divider lanes out of step");

   // A stalled result freezes the pipeline, so nothing new enters behind it.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(s1_valid_ff) && rsp.valid)
      else $error("pipeline moved while result stalled");

endmodule

// ===== tb/sv/vector3_normalize_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector3_normalize_test: self-checking bench for the vector normalizer
// Drives directed and random vector requests with bursty input and a stalling
// output, predicts magnitude and Q1.15 unit components, and compares in order.
// ----------------------------------------------------------------------------
module vector3_normalize_test;
   import vn_pkg::*;

   localparam int CB = 16;
   localparam int LATENCY = CB + 20;
   localparam int RANDOM_COUNT = 1400;

   typedef struct packed {
      logic [CB-1:0] length;
      unit_type      unit_x;
      unit_type      unit_y;
      unit_type      unit_z;
      logic          zero_vector;
   } norm_result_type;

   typedef struct {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] z;
      bit                   typed;
      norm_result_type      want;
   } vector_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vn_req_if #(.COMPONENT_BITS(CB)) req ();
   vn_rsp_if #(.COMPONENT_BITS(CB)) rsp ();

   vector3_normalize #(.COMPONENT_BITS(CB)) uut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   norm_result_type pending_results[$];
   int              mismatch_count = 0;
   bit              hold_off = 1'b0;

   // Floor square root by the digit-by-digit method.
   function automatic logic [CB-1:0] floor_root(input logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > n) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (n >= root + bit_val) begin
            n = n - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return root[CB-1:0];
   endfunction

   // Component over length in Q1.15, truncated toward zero; +1.0 saturates.
   function automatic unit_type unit_part(input logic signed [CB-1:0] comp,
                                          input logic [63:0] len);
      logic [63:0]        mag;
      logic [63:0]        quo;
      logic signed [63:0] signed_quo;
      mag = comp < 0 ? 64'(-64'(comp)) : 64'(comp);
      quo = (mag << UNIT_FRAC) / len;
      if (quo > 64'd32768) quo = 64'd32768;
      signed_quo = comp < 0 ? -$signed(quo) : $signed(quo);
      if (signed_quo > 32767) signed_quo = 32767;
      if (signed_quo < -32768) signed_quo = -32768;
      return signed_quo[15:0];
   endfunction

   function automatic norm_result_type normalize(input logic signed [CB-1:0] x,
                                                 input logic signed [CB-1:0] y,
                                                 input logic signed [CB-1:0] z);
      norm_result_type    r;
      logic signed [63:0] wx;
      logic signed [63:0] wy;
      logic signed [63:0] wz;
      logic [63:0]        sum;
      logic [63:0]        len;
      wx = x;
      wy = y;
      wz = z;
      sum = 64'(wx * wx + wy * wy + wz * wz);
      r = '0;
      if (sum == 0) begin
         r.zero_vector = 1'b1;
         return r;
      end
      len = 64'(floor_root(sum));
      r.length = len[CB-1:0];
      r.unit_x = unit_part(x, len);
      r.unit_y = unit_part(y, len);
      r.unit_z = unit_part(z, len);
      return r;
   endfunction

   // Directed rows. Expected values are typed only where they are obvious;
   // the rest fall back on the predictor.
   vector_row_type directed_rows[] = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}},
      '{16'sd1, 16'sd0, 16'sd0, 1'b1, '{16'd1, 16'sd32767, 16'sd0, 16'sd0, 1'b0}},
      '{-16'sd1, 16'sd0, 16'sd0, 1'b1, '{16'd1, -16'sd32768, 16'sd0, 16'sd0, 1'b0}},
      '{16'sd0, 16'sd32767, 16'sd0, 1'b1,
        '{16'd32767, 16'sd0, 16'sd32767, 16'sd0, 1'b0}},
      '{16'sd0, 16'sd0, -16'sd32768, 1'b1,
        '{16'd32768, 16'sd0, 16'sd0, -16'sd32768, 1'b0}},
      '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
      '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
      '{16'sd32767, -16'sd32768, 16'sd32767, 1'b0, '0},
      '{16'sd3, 16'sd4, 16'sd0, 1'b0, '0},
      '{16'sd2, 16'sd3, 16'sd6, 1'b0, '0},
      '{-16'sd1, -16'sd1, -16'sd1, 1'b0, '0},
      '{16'sd1, 16'sd1, 16'sd0, 1'b0, '0},
      '{16'sd0, 16'sd0, 16'sd1, 1'b1, '{16'd1, 16'sd0, 16'sd0, 16'sd32767, 1'b0}},
      '{16'sh5555, -16'sh5556, 16'sh2AAA, 1'b0, '0}
   };

   // Pick a component: full range half the time, otherwise tiny, small or extreme values.
   function automatic logic signed [CB-1:0] pick_component();
      case ($urandom_range(0, 5))
         0: return CB'($signed($urandom_range(0, 6)) - 3);
         1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         2: return CB'($signed($urandom_range(0, 400)) - 200);
         default: return CB'($urandom);
      endcase
   endfunction

   // Offer one request and hold it until accepted. The sender usually idles between
   // bursts so that gaps fall on every pipeline phase.
   task automatic send_vector(input logic signed [CB-1:0] x,
                              input logic signed [CB-1:0] y,
                              input logic signed [CB-1:0] z,
                              inout int burst_left);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req.valid   <= 1'b1;
      req.x_value <= x;
      req.y_value <= y;
      req.z_value <= z;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      burst_left--;
   endtask

   // Expectations are queued at the acceptance edge, in request order.
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         pending_results.push_back(normalize(req.x_value, req.y_value, req.z_value));
      end
   end

   // Typed rows are checked against their written value up front, so a
   // predictor fault shows up as a mismatch too.
   task automatic check_typed_row(input vector_row_type row);
      if (normalize(row.x, row.y, row.z) !== row.want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("typed row (%0d,%0d,%0d): table %p predictor %p",
                     row.x, row.y, row.z, row.want, normalize(row.x, row.y, row.z));
      end
   endtask

   // Receiver: stalls on a repeating pattern, with one long hold-off.
   int rsp_cycle = 0;
   always @(posedge clock) begin
      rsp_cycle <= rsp_cycle + 1;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_off) begin
         rsp.ready <= 1'b0;
      end else if ((rsp_cycle % 97) < 40) begin
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      hold_off = 1'b0;
      @(negedge reset);
      repeat (300) @(posedge clock);
      hold_off <= 1'b1;
      repeat (3 * LATENCY) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Result checker: compares each accepted result with the oldest prediction.
   always @(posedge clock) begin
      norm_result_type got;
      norm_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.length, rsp.unit_x, rsp.unit_y, rsp.unit_z, rsp.zero_vector};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   initial begin
      int burst_left;
      burst_left = 0;
      req.valid   <= 1'b0;
      req.x_value <= '0;
      req.y_value <= '0;
      req.z_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) check_typed_row(directed_rows[i]);
         send_vector(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                     burst_left);
      end

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         send_vector(pick_component(), pick_component(), pick_component(), burst_left);
      end
      req.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
